// File: hw/rtl/mi3_pkg.sv
// Shared types, widths and cofactor index tables for the 3x3 inverse.
package mi3_pkg;

   localparam int ENTRY_WIDTH = 16;
   localparam int FRAC_BITS   = 8;
   localparam int NUM_ENTRIES = 9;

   localparam int PROD_W = 2 * ENTRY_WIDTH;          // entry * entry
   localparam int COF_W  = 2 * ENTRY_WIDTH + 1;      // cofactor, exact
   localparam int DET_W  = 3 * ENTRY_WIDTH + 2;      // determinant, exact
   localparam int NUM_W  = COF_W + 2 * FRAC_BITS + 2; // 2|adj<<2F| + |det|
   localparam int DEN_W  = DET_W + 1;                // 2|det|
   localparam int CMP_W  = DEN_W + ENTRY_WIDTH;      // divisor at top shift

   localparam int FRONT_LAT = 4;
   localparam int LANE_LAT  = ENTRY_WIDTH + 3;
   localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

   // adj[i] = m[A]*m[B] - m[C]*m[D]
   localparam int CO_A [NUM_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int CO_B [NUM_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int CO_C [NUM_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int CO_D [NUM_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef logic signed [COF_W-1:0]       cof_type;
   typedef logic signed [DET_W-1:0]       det_type;

   typedef struct packed {
      entry_type a00;
      entry_type a01;
      entry_type a02;
      entry_type a10;
      entry_type a11;
      entry_type a12;
      entry_type a20;
      entry_type a21;
      entry_type a22;
   } req_type;

   typedef struct packed {
      entry_type b00;
      entry_type b01;
      entry_type b02;
      entry_type b10;
      entry_type b11;
      entry_type b12;
      entry_type b20;
      entry_type b21;
      entry_type b22;
      logic      singular;
   } rsp_type;

endpackage

// File: hw/rtl/mi3_adj.sv
// Cofactor / adjugate and determinant pipeline, four stages.
module mi3_adj (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  mi3_pkg::req_type       mat_in,
   output logic                   valid_out,
   output mi3_pkg::cof_type       adj_out [mi3_pkg::NUM_ENTRIES],
   output mi3_pkg::det_type       det_out
);

   localparam int N = mi3_pkg::NUM_ENTRIES;

   mi3_pkg::entry_type m [N];

   logic [mi3_pkg::FRONT_LAT-1:0] vld_ff;

   logic signed [mi3_pkg::PROD_W-1:0] prod_in [2*N];
   logic signed [mi3_pkg::PROD_W-1:0] prod_ff [2*N];
   mi3_pkg::entry_type row1_ff [3];
   mi3_pkg::entry_type row2_ff [3];

   mi3_pkg::cof_type adj_in  [N];
   mi3_pkg::cof_type adj_ff  [N];
   mi3_pkg::cof_type adj3_ff [N];
   mi3_pkg::cof_type adj4_ff [N];

   mi3_pkg::det_type dp_in [3];
   mi3_pkg::det_type dp_ff [3];
   mi3_pkg::det_type det_in;
   mi3_pkg::det_type det_ff;

   always_comb begin
      m[0] = mat_in.a00; m[1] = mat_in.a01; m[2] = mat_in.a02;
      m[3] = mat_in.a10; m[4] = mat_in.a11; m[5] = mat_in.a12;
      m[6] = mat_in.a20; m[7] = mat_in.a21; m[8] = mat_in.a22;
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         prod_in[2*i]   = mi3_pkg::PROD_W'(m[mi3_pkg::CO_A[i]]) *
                          mi3_pkg::PROD_W'(m[mi3_pkg::CO_B[i]]);
         prod_in[2*i+1] = mi3_pkg::PROD_W'(m[mi3_pkg::CO_C[i]]) *
                          mi3_pkg::PROD_W'(m[mi3_pkg::CO_D[i]]);
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         adj_in[i] = mi3_pkg::COF_W'(prod_ff[2*i]) - mi3_pkg::COF_W'(prod_ff[2*i+1]);
      end
   end

   // expansion along the first row: a0j times cofactor C0j = adj[3j]
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dp_in[k] = mi3_pkg::DET_W'(row2_ff[k]) * mi3_pkg::DET_W'(adj_ff[3*k]);
      end
      det_in = dp_ff[0] + dp_ff[1] + dp_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[mi3_pkg::FRONT_LAT-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      row1_ff <= '{m[0], m[1], m[2]};
      row2_ff <= row1_ff;
      adj_ff  <= adj_in;
      dp_ff   <= dp_in;
      adj3_ff <= adj_ff;
      adj4_ff <= adj3_ff;
      det_ff  <= det_in;
   end

   assign valid_out = vld_ff[mi3_pkg::FRONT_LAT-1];
   assign adj_out   = adj4_ff;
   assign det_out   = det_ff;

endmodule

// File: hw/rtl/mi3_div_lane.sv
// One division lane: rounded, saturated adj / det, one quotient bit per stage.
module mi3_div_lane (
   input  logic               clock,
   input  mi3_pkg::cof_type   adj_in,
   input  mi3_pkg::det_type   det_in,
   output mi3_pkg::entry_type quo_out
);

   localparam int E  = mi3_pkg::ENTRY_WIDTH;
   localparam int NS = E + 2;   // prep stage plus overflow check plus E bits

   logic [mi3_pkg::COF_W-1:0] nmag;
   logic [mi3_pkg::DET_W-1:0] dmag;

   logic [mi3_pkg::NUM_W-1:0] rem_ff [NS];
   logic [mi3_pkg::NUM_W-1:0] rem_in [NS];
   logic [mi3_pkg::DEN_W-1:0] den_ff [NS];
   logic [E-1:0]              q_ff   [NS];
   logic [E-1:0]              q_in   [NS];
   logic                      neg_ff [NS];
   logic                      ovf_ff [NS];
   logic                      ovf_in [NS];

   mi3_pkg::entry_type quo_in;
   mi3_pkg::entry_type quo_ff;

   always_comb begin
      nmag = adj_in[mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-adj_in) : adj_in;
      dmag = det_in[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det_in) : det_in;
      // q = (2n*2^(2F) + d) / (2d): round half away from zero on magnitudes
      rem_in[0] = (mi3_pkg::NUM_W'(nmag) << (2 * mi3_pkg::FRAC_BITS + 1)) +
                  mi3_pkg::NUM_W'(dmag);
      q_in[0]   = '0;
      ovf_in[0] = 1'b0;
      // stage 1 tests the divisor at shift E (overflow), later stages one bit each
      for (int k = 1; k < NS; k++) begin
         logic [mi3_pkg::CMP_W-1:0] sub;
         logic                      ge;
         sub = mi3_pkg::CMP_W'(den_ff[k-1]) << (E + 1 - k);
         ge  = mi3_pkg::CMP_W'(rem_ff[k-1]) >= sub;
         rem_in[k] = rem_ff[k-1];
         q_in[k]   = q_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         if (k == 1) begin
            ovf_in[k] = ge;
         end else if (ge) begin
            rem_in[k]       = rem_ff[k-1] - mi3_pkg::NUM_W'(sub);
            q_in[k][E+1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      den_ff[0] <= {dmag, 1'b0};
      q_ff[0]   <= q_in[0];
      neg_ff[0] <= adj_in[mi3_pkg::COF_W-1] ^ det_in[mi3_pkg::DET_W-1];
      ovf_ff[0] <= ovf_in[0];
      for (int k = 1; k < NS; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_ff[k-1];
         q_ff[k]   <= q_in[k];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_in[k];
      end
      quo_ff <= quo_in;
   end

   always_comb begin
      logic [E-1:0] q;
      q = q_ff[NS-1];
      if (neg_ff[NS-1]) begin
         if (ovf_ff[NS-1] || (q > {1'b1, {(E-1){1'b0}}})) begin
            quo_in = {1'b1, {(E-1){1'b0}}};
         end else begin
            quo_in = -q;
         end
      end else begin
         if (ovf_ff[NS-1] || q[E-1]) begin
            quo_in = {1'b0, {(E-1){1'b1}}};
         end else begin
            quo_in = q;
         end
      end
   end

   assign quo_out = quo_ff;

endmodule

// File: hw/rtl/matrix3x3_inverse.sv
// Top level: adjugate front end, nine division lanes and the result merge.
//
// Accepts one matrix word per clock (busy is always low) and gives its inverse
// as one result word, marked by rsp_valid for one cycle; results come out in
// order and the receiver cannot stall them. The result path runs through the
// cofactor and determinant arithmetic, the bit-per-stage divider lanes (one per
// inverse entry) and the merge register. A zero determinant gives singular = 1
// and all entries zero.
module matrix3x3_inverse (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mi3_pkg::req_type req_data,
   output logic             rsp_valid,
   output mi3_pkg::rsp_type rsp_data
);

   localparam int N = mi3_pkg::NUM_ENTRIES;
   localparam int L = mi3_pkg::LANE_LAT;

   logic             front_vld;
   mi3_pkg::cof_type adj [N];
   mi3_pkg::det_type det;

   mi3_pkg::entry_type quo [N];

   logic [L-1:0] vld_ff;
   logic [L-1:0] sing_ff;
   logic         rsp_valid_ff;
   mi3_pkg::rsp_type rsp_in;
   mi3_pkg::rsp_type rsp_ff;

   assign busy = 1'b0;

   mi3_adj u_adj (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start & ~busy),
      .mat_in    (req_data),
      .valid_out (front_vld),
      .adj_out   (adj),
      .det_out   (det)
   );

   for (genvar i = 0; i < N; i++) begin : g_lane
      mi3_div_lane u_lane (
         .clock   (clock),
         .adj_in  (adj[i]),
         .det_in  (det),
         .quo_out (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[L-2:0], front_vld};
         rsp_valid_ff <= vld_ff[L-1];
      end
   end

   always_ff @(posedge clock) begin
      sing_ff <= {sing_ff[L-2:0], (det == '0)};
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      logic s;
      s = sing_ff[L-1];
      rsp_in.b00      = s ? '0 : quo[0];
      rsp_in.b01      = s ? '0 : quo[1];
      rsp_in.b02      = s ? '0 : quo[2];
      rsp_in.b10      = s ? '0 : quo[3];
      rsp_in.b11      = s ? '0 : quo[4];
      rsp_in.b12      = s ? '0 : quo[5];
      rsp_in.b20      = s ? '0 : quo[6];
      rsp_in.b21      = s ? '0 : quo[7];
      rsp_in.b22      = s ? '0 : quo[8];
      rsp_in.singular = s;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
